>>> src/crht_pkg.sv
package crht_pkg;

  localparam int RADIUS_BITS = 14;
  localparam int R2_BITS = 2 * RADIUS_BITS;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 14'd48;

  localparam int NUM_CORNERS = 4;

  // front stages plus edge stages, start to strobe
  localparam int FRONT_STAGES = 3;
  localparam int EDGE_STAGES = 4;
  localparam int LATENCY = FRONT_STAGES + EDGE_STAGES;

  typedef struct packed {
    logic valid;
    logic active;
    logic near_hit;
  } ctl_t;

  // corner that closes the edge starting at corner idx
  function automatic int next_corner(input int idx);
    return (idx + 1) % NUM_CORNERS;
  endfunction

endpackage

>>> src/circle_rectangle_hit_test.sv
// a transaction passes the front stages and then the edge stages before its result shows on hit_valid_o
// throughput: one transaction per cycle, busy is tied low, seven in flight at most
// the pace is set by the edge distance path: squared cross product against squared
// edge length times radius squared, split into half-width partial products
// reset: rst_ni low clears all valid bits at once and loads the radius with 48
module circle_rectangle_hit_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_BITS-1:0]     center_x_i,
  input  logic signed [COORD_BITS-1:0]     center_y_i,
  input  logic signed [COORD_BITS-1:0]     corner_a_x_i,
  input  logic signed [COORD_BITS-1:0]     corner_a_y_i,
  input  logic signed [COORD_BITS-1:0]     corner_b_x_i,
  input  logic signed [COORD_BITS-1:0]     corner_b_y_i,
  input  logic signed [COORD_BITS-1:0]     corner_c_x_i,
  input  logic signed [COORD_BITS-1:0]     corner_c_y_i,
  input  logic signed [COORD_BITS-1:0]     corner_d_x_i,
  input  logic signed [COORD_BITS-1:0]     corner_d_y_i,
  input  logic                             laser_active_i,
  input  logic                             cfg_we_i,
  input  logic [crht_pkg::RADIUS_BITS-1:0] cfg_data_i,
  output logic                             hit_valid_o,
  output logic                             hit_o
);

  localparam int NC  = crht_pkg::NUM_CORNERS;
  localparam int AW  = 2 * COORD_BITS + 1;
  localparam int BW  = AW + 1;
  localparam int R2W = crht_pkg::R2_BITS;
  localparam int ES  = crht_pkg::EDGE_STAGES;

  // radius register; the user must write it only while the pipe is empty, the block does not check this
  logic [crht_pkg::RADIUS_BITS-1:0] hit_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_radius_q <= crht_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      hit_radius_q <= cfg_data_i;
    end
  end

  // every cycle can take a transaction
  assign busy = 1'b0;

  crht_pkg::ctl_t               ctl_in;
  crht_pkg::ctl_t               ctl_front;
  logic signed [COORD_BITS-1:0] px [NC];
  logic signed [COORD_BITS-1:0] py [NC];
  logic [AW-1:0]                edge_a  [NC];
  logic signed [BW-1:0]         edge_b  [NC];
  logic signed [BW-1:0]         edge_cr [NC];
  logic [R2W-1:0]               r2;
  logic [NC-1:0]                edge_hit;

  always_comb begin
    ctl_in.valid    = start && !busy;
    ctl_in.active   = laser_active_i;
    ctl_in.near_hit = 1'b0;
  end

  // corners in order around the rectangle
  assign px[0] = corner_a_x_i;
  assign py[0] = corner_a_y_i;
  assign px[1] = corner_b_x_i;
  assign py[1] = corner_b_y_i;
  assign px[2] = corner_c_x_i;
  assign py[2] = corner_c_y_i;
  assign px[3] = corner_d_x_i;
  assign py[3] = corner_d_y_i;

  // stages 1 to 3: offsets, products, corner and inside tests
  crht_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_in),
    .cx_i     (center_x_i),
    .cy_i     (center_y_i),
    .px_i     (px),
    .py_i     (py),
    .radius_i (hit_radius_q),
    .ctl_o    (ctl_front),
    .a_o      (edge_a),
    .b_o      (edge_b),
    .cr_o     (edge_cr),
    .r2_o     (r2)
  );

  // stages 4 to 7: one distance unit per edge, nearest point inside the segment
  // (the clamped end cases are corner hits and already counted)
  for (genvar g = 0; g < NC; g++) begin : g_edge
    crht_edge #(
      .COORD_BITS (COORD_BITS)
    ) u_edge (
      .clk_i (clk_i),
      .a_i   (edge_a[g]),
      .b_i   (edge_b[g]),
      .cr_i  (edge_cr[g]),
      .r2_i  (r2),
      .hit_o (edge_hit[g])
    );
  end

  // control travels alongside the edge units
  crht_pkg::ctl_t ctl_dly_q [ES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ES; i++) begin
        ctl_dly_q[i] <= '0;
      end
    end else begin
      ctl_dly_q[0] <= ctl_front;
      for (int i = 1; i < ES; i++) begin
        ctl_dly_q[i] <= ctl_dly_q[i-1];
      end
    end
  end

  // an inactive laser never hits
  assign hit_valid_o = ctl_dly_q[ES-1].valid;
  assign hit_o       = ctl_dly_q[ES-1].valid && ctl_dly_q[ES-1].active &&
                       (ctl_dly_q[ES-1].near_hit || (|edge_hit));

endmodule

>>> src/crht_front.sv
module crht_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  crht_pkg::ctl_t                      ctl_i,
  input  logic signed [COORD_BITS-1:0]        cx_i,
  input  logic signed [COORD_BITS-1:0]        cy_i,
  input  logic signed [COORD_BITS-1:0]        px_i [crht_pkg::NUM_CORNERS],
  input  logic signed [COORD_BITS-1:0]        py_i [crht_pkg::NUM_CORNERS],
  input  logic [crht_pkg::RADIUS_BITS-1:0]    radius_i,
  output crht_pkg::ctl_t                      ctl_o,
  output logic [2*COORD_BITS:0]               a_o  [crht_pkg::NUM_CORNERS],
  output logic signed [2*COORD_BITS+1:0]      b_o  [crht_pkg::NUM_CORNERS],
  output logic signed [2*COORD_BITS+1:0]      cr_o [crht_pkg::NUM_CORNERS],
  output logic [crht_pkg::R2_BITS-1:0]        r2_o
);

  localparam int NC   = crht_pkg::NUM_CORNERS;
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int AW   = 2 * COORD_BITS + 1;
  localparam int R2W  = crht_pkg::R2_BITS;
  localparam int CMPW = (PW > R2W) ? PW : R2W;

  // stage 1: differences
  crht_pkg::ctl_t          ctl1_q;
  logic signed [DW-1:0]    ex_q [NC];
  logic signed [DW-1:0]    ey_q [NC];
  logic signed [DW-1:0]    dx_q [NC];
  logic signed [DW-1:0]    dy_q [NC];
  logic [R2W-1:0]          r2_1_q;

  // stage 2: products
  crht_pkg::ctl_t          ctl2_q;
  logic signed [PW-1:0]    sqx_q [NC];
  logic signed [PW-1:0]    sqy_q [NC];
  logic signed [PW-1:0]    ddx_q [NC];
  logic signed [PW-1:0]    ddy_q [NC];
  logic signed [PW-1:0]    bx_q  [NC];
  logic signed [PW-1:0]    by_q  [NC];
  logic signed [PW-1:0]    crx_q [NC];
  logic signed [PW-1:0]    cry_q [NC];
  logic [R2W-1:0]          r2_2_q;

  // stage 3: sums, corner compares and inside test
  crht_pkg::ctl_t          ctl3_q;
  logic [AW-1:0]           a_q  [NC];
  logic signed [PW-1:0]    b_q  [NC];
  logic signed [PW-1:0]    cr_q [NC];
  logic [R2W-1:0]          r2_3_q;

  logic signed [PW-1:0]    dist_d [NC];
  logic signed [PW-1:0]    b_d    [NC];
  logic signed [PW-1:0]    cr_d   [NC];
  logic [NC-1:0]           corner_d;
  logic                    inside_d;
  crht_pkg::ctl_t          ctl3_d;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NC; i++) begin
      ex_q[i] <= DW'(px_i[i]) - DW'(cx_i);
      ey_q[i] <= DW'(py_i[i]) - DW'(cy_i);
      dx_q[i] <= DW'(px_i[crht_pkg::next_corner(i)]) - DW'(px_i[i]);
      dy_q[i] <= DW'(py_i[crht_pkg::next_corner(i)]) - DW'(py_i[i]);
    end
    r2_1_q <= R2W'(radius_i) * R2W'(radius_i);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NC; i++) begin
      sqx_q[i] <= PW'(ex_q[i]) * PW'(ex_q[i]);
      sqy_q[i] <= PW'(ey_q[i]) * PW'(ey_q[i]);
      ddx_q[i] <= PW'(dx_q[i]) * PW'(dx_q[i]);
      ddy_q[i] <= PW'(dy_q[i]) * PW'(dy_q[i]);
      bx_q[i]  <= PW'(dx_q[i]) * PW'(ex_q[i]);
      by_q[i]  <= PW'(dy_q[i]) * PW'(ey_q[i]);
      crx_q[i] <= PW'(dx_q[i]) * PW'(ey_q[i]);
      cry_q[i] <= PW'(dy_q[i]) * PW'(ex_q[i]);
    end
    r2_2_q <= r2_1_q;
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      dist_d[i]   = sqx_q[i] + sqy_q[i];
      b_d[i]      = bx_q[i] + by_q[i];
      cr_d[i]     = crx_q[i] - cry_q[i];
      corner_d[i] = CMPW'($unsigned(dist_d[i])) < CMPW'(r2_2_q);
    end
    // centre inside: cross and dot at corner a and at corner c are both
    // non-negative, which is cross and dot of the edge terms non-positive
    inside_d = (cr_d[0][PW-1] || (cr_d[0] == '0)) &&
               (b_d[0][PW-1]  || (b_d[0]  == '0)) &&
               (cr_d[2][PW-1] || (cr_d[2] == '0)) &&
               (b_d[2][PW-1]  || (b_d[2]  == '0));
    ctl3_d          = ctl2_q;
    ctl3_d.near_hit = (|corner_d) || inside_d;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NC; i++) begin
      a_q[i]  <= AW'($unsigned(ddx_q[i] + ddy_q[i]));
      b_q[i]  <= b_d[i];
      cr_q[i] <= cr_d[i];
    end
    r2_3_q <= r2_2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl3_d;
    end
  end

  assign ctl_o = ctl3_q;
  assign r2_o  = r2_3_q;
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      a_o[i]  = a_q[i];
      b_o[i]  = b_q[i];
      cr_o[i] = cr_q[i];
    end
  end

endmodule

>>> src/crht_edge.sv
module crht_edge #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic [2*COORD_BITS:0]           a_i,
  input  logic signed [2*COORD_BITS+1:0]  b_i,
  input  logic signed [2*COORD_BITS+1:0]  cr_i,
  input  logic [crht_pkg::R2_BITS-1:0]    r2_i,
  output logic                            hit_o
);

  localparam int AW  = 2 * COORD_BITS + 1;
  localparam int BW  = AW + 1;
  localparam int R2W = crht_pkg::R2_BITS;
  localparam int LO  = (AW + 1) / 2;
  localparam int HI  = AW - LO;
  localparam int HHW = 2 * HI;
  localparam int HLW = HI + LO;
  localparam int LLW = 2 * LO;
  localparam int AHW = HI + R2W;
  localparam int ALW = LO + R2W;
  localparam int SQW = 2 * AW;
  localparam int ARW = AW + R2W;
  localparam int MW  = (SQW > ARW) ? SQW : ARW;

  logic signed [BW-1:0] sum_ab;
  logic                 perp_d;

  logic                 perp1_q, perp2_q, perp3_q;
  logic [AW-1:0]        mag_q;
  logic [AW-1:0]        a1_q;
  logic [R2W-1:0]       r2_q;
  logic [HHW-1:0]       hh_q;
  logic [HLW-1:0]       hl_q;
  logic [LLW-1:0]       ll_q;
  logic [AHW-1:0]       ah_q;
  logic [ALW-1:0]       al_q;
  logic [SQW-1:0]       sq_q;
  logic [ARW-1:0]       ar_q;
  logic                 hit_q;

  // nearest point strictly inside the segment: non-zero length, b < 0, a + b > 0
  assign sum_ab = $signed({1'b0, a_i}) + b_i;
  assign perp_d = (a_i != '0) && b_i[BW-1] && !sum_ab[BW-1] && (sum_ab != '0);

  always_ff @(posedge clk_i) begin
    perp1_q <= perp_d;
    mag_q   <= cr_i[BW-1] ? AW'(-cr_i) : AW'(cr_i);
    a1_q    <= a_i;
    r2_q    <= r2_i;
  end

  // split squares and length products into half-width partial products
  always_ff @(posedge clk_i) begin
    perp2_q <= perp1_q;
    hh_q    <= HHW'(mag_q[AW-1:LO]) * HHW'(mag_q[AW-1:LO]);
    hl_q    <= HLW'(mag_q[AW-1:LO]) * HLW'(mag_q[LO-1:0]);
    ll_q    <= LLW'(mag_q[LO-1:0]) * LLW'(mag_q[LO-1:0]);
    ah_q    <= AHW'(a1_q[AW-1:LO]) * AHW'(r2_q);
    al_q    <= ALW'(a1_q[LO-1:0]) * ALW'(r2_q);
  end

  always_ff @(posedge clk_i) begin
    perp3_q <= perp2_q;
    sq_q    <= (SQW'(hh_q) << (2 * LO)) + (SQW'(hl_q) << (LO + 1)) + SQW'(ll_q);
    ar_q    <= (ARW'(ah_q) << LO) + ARW'(al_q);
  end

  always_ff @(posedge clk_i) begin
    hit_q <= perp3_q && (MW'(sq_q) < MW'(ar_q));
  end

  assign hit_o = hit_q;

endmodule

>>> src/crht_checker.sv
module crht_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic laser_active_i,
  input logic hit_valid_o,
  input logic hit_o
);

  localparam int LAT = crht_pkg::LATENCY;

  // every accepted transaction gives its result after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT hit_valid_o)
    else $error("accepted transaction produced no result");

  // no result without a transaction accepted the same latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_o |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  // a hit comes only from an active laser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_valid_o && hit_o) |-> $past(laser_active_i, LAT))
    else $error("hit reported for an inactive laser");

  // hit stays low outside the strobe cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_valid_o |-> !hit_o)
    else $error("hit high without strobe");

endmodule

bind circle_rectangle_hit_test crht_checker u_crht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .laser_active_i (laser_active_i),
  .hit_valid_o    (hit_valid_o),
  .hit_o          (hit_o)
);
